// File: rtl/rmmm_pkg.sv
// Shared types and constants for the running min/max/mean core.
// Command and status bundles between controller and datapath; no dependencies.
package rmmm_pkg;

  localparam int MEAN_W = 32;

  typedef struct packed {
    logic capture;   // latch the incoming request
    logic prep;      // form difference, load divider
    logic div_step;  // one restoring-division step
    logic commit;    // update statistics
  } rmmm_cmd_t;

  typedef struct packed {
    logic skip_div;  // clear request or first sample: no division needed
  } rmmm_stat_t;

endpackage

// File: rtl/rmmm_ctrl.sv
// Sequencer for the running min/max/mean core.
// Drives the handshakes and issues commands to rmmm_dpath; uses rmmm_pkg.
module rmmm_ctrl #(
  parameter int DIV_STEPS = 33
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rmmm_pkg::rmmm_stat_t stat,
  output rmmm_pkg::rmmm_cmd_t  cmd
);
  import rmmm_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_FIN
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r;
  logic             out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state_r == S_IDLE) && in_valid;
    cmd.prep     = (state_r == S_PREP);
    cmd.div_step = (state_r == S_DIV);
    cmd.commit   = (state_r == S_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          cnt_r <= '0;
          if (stat.skip_div) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == LAST_STEP) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/rmmm_dpath.sv
// Datapath for the running min/max/mean core: statistics registers,
// mean difference and a bit-serial restoring divider. Uses rmmm_pkg.
module rmmm_dpath #(
  parameter int SAMPLE_BITS   = 24,
  parameter int FRACTION_BITS = 8,
  parameter int COUNT_BITS    = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rmmm_pkg::rmmm_cmd_t           cmd,
  output rmmm_pkg::rmmm_stat_t          stat,
  input  logic                          in_req_type,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic [COUNT_BITS-1:0]         out_count,
  output logic signed [rmmm_pkg::MEAN_W-1:0] out_mean,
  output logic signed [SAMPLE_BITS-1:0] out_minimum,
  output logic signed [SAMPLE_BITS-1:0] out_maximum
);
  import rmmm_pkg::*;

  localparam int SF_W  = SAMPLE_BITS + FRACTION_BITS;
  localparam int DW    = ((SF_W > MEAN_W) ? SF_W : MEAN_W) + 1;
  localparam int SW    = DW + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic signed [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic signed [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

  function automatic logic signed [MEAN_W-1:0] sat_mean(input logic signed [SW-1:0] v);
    logic [SW-MEAN_W:0] top;
    top = v[SW-1:MEAN_W-1];
    if ((&top) || !(|top)) begin
      sat_mean = v[MEAN_W-1:0];
    end else if (v[SW-1]) begin
      sat_mean = MEAN_MIN;
    end else begin
      sat_mean = MEAN_MAX;
    end
  endfunction

  logic                          req_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic [COUNT_BITS-1:0]         count_r;
  logic signed [MEAN_W-1:0]      mean_r;
  logic signed [SAMPLE_BITS-1:0] min_r;
  logic signed [SAMPLE_BITS-1:0] max_r;
  logic [COUNT_BITS-1:0]         divisor_r;
  logic [COUNT_BITS-1:0]         rem_r;
  logic [DW-1:0]                 quo_r;
  logic                          neg_r;

  logic signed [DW-1:0]   sample_ext;
  logic signed [DW-1:0]   scaled;
  logic signed [DW-1:0]   diff;
  logic [DW-1:0]          diff_abs;
  logic [COUNT_BITS:0]    trial;
  logic [COUNT_BITS:0]    trial_sub;
  logic signed [SW-1:0]   delta;
  logic signed [SW-1:0]   mean_sum;
  logic signed [SW-1:0]   scaled_ext;

  assign sample_ext = {{(DW-SAMPLE_BITS){sample_r[SAMPLE_BITS-1]}}, sample_r};
  assign scaled     = sample_ext <<< FRACTION_BITS;
  assign scaled_ext = {scaled[DW-1], scaled};
  assign diff       = scaled - {{(DW-MEAN_W){mean_r[MEAN_W-1]}}, mean_r};
  assign diff_abs   = diff[DW-1] ? (~diff + DW'(1)) : diff;

  assign trial     = {rem_r, quo_r[DW-1]};
  assign trial_sub = trial - {1'b0, divisor_r};

  assign delta    = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign mean_sum = {{(SW-MEAN_W){mean_r[MEAN_W-1]}}, mean_r} + delta;

  assign stat.skip_div = req_r || (count_r == '0);

  assign out_count   = count_r;
  assign out_mean    = mean_r;
  assign out_minimum = min_r;
  assign out_maximum = max_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r    <= in_req_type;
      sample_r <= in_sample;
    end
    if (cmd.prep) begin
      neg_r     <= diff[DW-1];
      quo_r     <= diff_abs;
      rem_r     <= '0;
      divisor_r <= (count_r == COUNT_MAX) ? COUNT_MAX : (count_r + COUNT_BITS'(1));
    end else if (cmd.div_step) begin
      if (!trial_sub[COUNT_BITS]) begin
        rem_r <= trial_sub[COUNT_BITS-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= trial[COUNT_BITS-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      mean_r  <= '0;
      min_r   <= '0;
      max_r   <= '0;
    end else if (cmd.commit) begin
      if (req_r) begin
        count_r <= '0;
        mean_r  <= '0;
        min_r   <= '0;
        max_r   <= '0;
      end else if (count_r == '0) begin
        count_r <= COUNT_BITS'(1);
        mean_r  <= sat_mean(scaled_ext);
        min_r   <= sample_r;
        max_r   <= sample_r;
      end else begin
        count_r <= divisor_r;
        mean_r  <= sat_mean(mean_sum);
        if (sample_r < min_r) begin
          min_r <= sample_r;
        end
        if (sample_r > max_r) begin
          max_r <= sample_r;
        end
      end
    end
  end

endmodule

// File: rtl/running_min_max_mean_core.sv
// Top level of the running min/max/mean core.
// Instantiates rmmm_ctrl and rmmm_dpath; uses rmmm_pkg.
//
// Each request either adds a signed sample or clears the statistics, and
// returns one result holding count, mean (FRACTION_BITS fraction bits),
// minimum and maximum after the update. One request is processed at a time.
// A clear or the first sample after a clear goes from acceptance through the
// prepare and finish states to the result; any other sample also passes
// through the division state, where the restoring divider produces one
// quotient bit per cycle. A finished result waits in the output stage while
// the next request is accepted.
module running_min_max_mean_core #(
  parameter int SAMPLE_BITS   = 24,
  parameter int FRACTION_BITS = 8,
  parameter int COUNT_BITS    = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COUNT_BITS-1:0]         out_count,
  output logic signed [rmmm_pkg::MEAN_W-1:0] out_mean,
  output logic signed [SAMPLE_BITS-1:0] out_minimum,
  output logic signed [SAMPLE_BITS-1:0] out_maximum
);
  import rmmm_pkg::*;

  localparam int SF_W      = SAMPLE_BITS + FRACTION_BITS;
  localparam int DIV_STEPS = ((SF_W > MEAN_W) ? SF_W : MEAN_W) + 1;

  rmmm_cmd_t  cmd;
  rmmm_stat_t stat;

  rmmm_ctrl #(
    .DIV_STEPS(DIV_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rmmm_dpath #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRACTION_BITS(FRACTION_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_req_type(in_req_type),
    .in_sample  (in_sample),
    .out_count  (out_count),
    .out_mean   (out_mean),
    .out_minimum(out_minimum),
    .out_maximum(out_maximum)
  );

endmodule
